/* hw/rtl/sc1a_pkg.sv */
// ----------------------------------------------------------------------------
// sc1a_pkg
// Shared types, scan codes and key maps for the set-1 scan code decoder.
// ----------------------------------------------------------------------------
package sc1a_pkg;

  // Scan codes with a special meaning.
  localparam logic [7:0] CODE_EXT_PREFIX = 8'hE0;
  localparam logic [7:0] CODE_LSHIFT_MK  = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT_MK  = 8'h36;
  localparam logic [7:0] CODE_CAPS_MK    = 8'h3A;
  localparam logic [7:0] CODE_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] MAP_SIZE        = 8'd58;
  localparam logic [6:0] CASE_DELTA      = 7'd32;

  // Width of the characters that leave the block.
  localparam int CHAR_W = 7;

  // Decoder flags, held in the state memory.
  typedef struct packed {
    logic ext_pending;
    logic shift_held;
    logic caps_locked;
  } flags_t;

  localparam int FLAGS_W     = $bits(flags_t);
  localparam int STATE_DEPTH = 1;

  // Character for a make code with shift released.
  function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      6'h02: ch = 7'h31;  6'h03: ch = 7'h32;  6'h04: ch = 7'h33;
      6'h05: ch = 7'h34;  6'h06: ch = 7'h35;  6'h07: ch = 7'h36;
      6'h08: ch = 7'h37;  6'h09: ch = 7'h38;  6'h0A: ch = 7'h39;
      6'h0B: ch = 7'h30;  6'h0C: ch = 7'h2D;  6'h0D: ch = 7'h3D;
      6'h0E: ch = 7'h08;  6'h10: ch = 7'h71;  6'h11: ch = 7'h77;
      6'h12: ch = 7'h65;  6'h13: ch = 7'h72;  6'h14: ch = 7'h74;
      6'h15: ch = 7'h79;  6'h16: ch = 7'h75;  6'h17: ch = 7'h69;
      6'h18: ch = 7'h6F;  6'h19: ch = 7'h70;  6'h1A: ch = 7'h5B;
      6'h1B: ch = 7'h5D;  6'h1C: ch = 7'h0A;  6'h1E: ch = 7'h61;
      6'h1F: ch = 7'h73;  6'h20: ch = 7'h64;  6'h21: ch = 7'h66;
      6'h22: ch = 7'h67;  6'h23: ch = 7'h68;  6'h24: ch = 7'h6A;
      6'h25: ch = 7'h6B;  6'h26: ch = 7'h6C;  6'h27: ch = 7'h3B;
      6'h28: ch = 7'h27;  6'h29: ch = 7'h60;  6'h2B: ch = 7'h5C;
      6'h2C: ch = 7'h7A;  6'h2D: ch = 7'h78;  6'h2E: ch = 7'h63;
      6'h2F: ch = 7'h76;  6'h30: ch = 7'h62;  6'h31: ch = 7'h6E;
      6'h32: ch = 7'h6D;  6'h33: ch = 7'h2C;  6'h34: ch = 7'h2E;
      6'h35: ch = 7'h2F;  6'h37: ch = 7'h2A;  6'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // Character for a make code with shift held.
  function automatic logic [CHAR_W-1:0] shifted_char(input logic [5:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      6'h01: ch = 7'h01;  6'h02: ch = 7'h21;  6'h03: ch = 7'h40;
      6'h04: ch = 7'h23;  6'h05: ch = 7'h24;  6'h06: ch = 7'h25;
      6'h07: ch = 7'h5E;  6'h08: ch = 7'h26;  6'h09: ch = 7'h2A;
      6'h0A: ch = 7'h28;  6'h0B: ch = 7'h29;  6'h0C: ch = 7'h5F;
      6'h0D: ch = 7'h2B;  6'h0E: ch = 7'h08;  6'h0F: ch = 7'h09;
      6'h10: ch = 7'h51;  6'h11: ch = 7'h57;  6'h12: ch = 7'h45;
      6'h13: ch = 7'h52;  6'h14: ch = 7'h54;  6'h15: ch = 7'h59;
      6'h16: ch = 7'h55;  6'h17: ch = 7'h49;  6'h18: ch = 7'h4F;
      6'h19: ch = 7'h50;  6'h1A: ch = 7'h7B;  6'h1B: ch = 7'h7D;
      6'h1C: ch = 7'h0A;  6'h1E: ch = 7'h41;  6'h1F: ch = 7'h53;
      6'h20: ch = 7'h44;  6'h21: ch = 7'h46;  6'h22: ch = 7'h47;
      6'h23: ch = 7'h48;  6'h24: ch = 7'h4A;  6'h25: ch = 7'h4B;
      6'h26: ch = 7'h4C;  6'h27: ch = 7'h3A;  6'h28: ch = 7'h22;
      6'h29: ch = 7'h7E;  6'h2B: ch = 7'h7C;  6'h2C: ch = 7'h5A;
      6'h2D: ch = 7'h58;  6'h2E: ch = 7'h43;  6'h2F: ch = 7'h56;
      6'h30: ch = 7'h42;  6'h31: ch = 7'h4E;  6'h32: ch = 7'h4D;
      6'h33: ch = 7'h3C;  6'h34: ch = 7'h3E;  6'h35: ch = 7'h3F;
      6'h37: ch = 7'h2A;  6'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

/* hw/rtl/sc1a_ram.sv */
// ----------------------------------------------------------------------------
// sc1a_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sc1a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; returns the old contents when read and write coincide.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/sc1a_decode.sv */
// ----------------------------------------------------------------------------
// sc1a_decode
// Flag update and key map lookup for one scan byte.
// ----------------------------------------------------------------------------
module sc1a_decode (
  input  logic [7:0]                  scan_byte_i,
  input  sc1a_pkg::flags_t            flags_i,
  output sc1a_pkg::flags_t            flags_o,
  output logic [sc1a_pkg::CHAR_W-1:0] char_o,
  output logic                        char_vld_o
);
  import sc1a_pkg::*;

  logic [CHAR_W-1:0] map_ch;

  // Prefix, break and make handling; the lookup sees the updated flags.
  always_comb begin
    flags_o = flags_i;
    map_ch  = '0;
    if (scan_byte_i == CODE_EXT_PREFIX) begin
      flags_o.ext_pending = 1'b1;
    end else if (flags_i.ext_pending) begin
      flags_o.ext_pending = 1'b0;
    end else if (scan_byte_i[7]) begin
      if (scan_byte_i inside {CODE_LSHIFT_BRK, CODE_RSHIFT_BRK}) begin
        flags_o.shift_held = 1'b0;
      end
    end else begin
      if (scan_byte_i inside {CODE_LSHIFT_MK, CODE_RSHIFT_MK}) begin
        flags_o.shift_held = 1'b1;
      end
      if (scan_byte_i == CODE_CAPS_MK) begin
        flags_o.caps_locked = ~flags_i.caps_locked;
      end
      if (scan_byte_i < MAP_SIZE) begin
        map_ch = flags_o.shift_held ? shifted_char(scan_byte_i[5:0])
                                    : plain_char(scan_byte_i[5:0]);
      end
    end
  end

  // Caps lock swaps the case of letters only.
  always_comb begin
    char_o = map_ch;
    if (flags_o.caps_locked) begin
      if (map_ch inside {[7'h61:7'h7A]}) begin
        char_o = map_ch - CASE_DELTA;
      end else if (map_ch inside {[7'h41:7'h5A]}) begin
        char_o = map_ch + CASE_DELTA;
      end
    end
    char_vld_o = (char_o != '0);
  end

endmodule

/* hw/rtl/scan_code_set1_to_ascii.sv */
// ----------------------------------------------------------------------------
// scan_code_set1_to_ascii
// Decodes set-1 keyboard scan bytes into ASCII characters, tracking the
// extended prefix, shift and caps lock flags in a small state memory.
//
//   Channel  Direction  tdata bits (low to high)
//   in_      slave      [7:0] scan_byte
//   out_     master     [6:0] ascii_char, [7] zero
//
// One byte is accepted per cycle while the output side keeps up. A byte
// reads the flag memory on acceptance, is decoded in the next cycle and
// writes the flags back; a write-to-read bypass covers back-to-back bytes.
// A byte that yields no character is dropped from the stream. Reset clears
// the pipeline and the memory's written mark, so the flags read as zero.
// A held output beat stalls the decode stage and then the input.
// ----------------------------------------------------------------------------
module scan_code_set1_to_ascii (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] scan_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [6:0] ascii_char, [7] zero
);
  import sc1a_pkg::*;

  localparam int ADDR_W = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] FLAGS_ADDR = '0;

  logic              s1_vld_r, s1_vld_nxt;
  logic [7:0]        s1_byte_r;
  logic              out_vld_r, out_vld_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              mem_init_r;
  logic              rd_init_r;
  logic              fwd_r;
  flags_t            wr_flags_r;
  flags_t            rd_flags;
  flags_t            cur_flags;
  flags_t            new_flags;
  logic [CHAR_W-1:0] dec_char;
  logic              dec_vld;
  logic              in_acc;
  logic              s1_go;
  logic              wr_en;

  // Handshake: the decode stage moves on when the output register is free.
  assign s1_go     = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = s1_go;

  // Flag state memory, read on acceptance and written back after decode.
  sc1a_ram #(
    .WIDTH(FLAGS_W),
    .DEPTH(STATE_DEPTH)
  ) u_flags_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(FLAGS_ADDR),
    .wr_data(new_flags),
    .rd_en  (in_acc),
    .rd_addr(FLAGS_ADDR),
    .rd_data(rd_flags)
  );

  // Bypass the write that coincided with the read; unwritten memory is zero.
  always_comb begin
    if (fwd_r) begin
      cur_flags = wr_flags_r;
    end else if (rd_init_r) begin
      cur_flags = rd_flags;
    end else begin
      cur_flags = '0;
    end
  end

  sc1a_decode u_decode (
    .scan_byte_i(s1_byte_r),
    .flags_i    (cur_flags),
    .flags_o    (new_flags),
    .char_o     (dec_char),
    .char_vld_o (dec_vld)
  );

  // Next-state logic for the stage and output valid bits.
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_go) begin
      out_vld_nxt = dec_vld;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      mem_init_r <= 1'b0;
      rd_init_r  <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (wr_en) begin
        mem_init_r <= 1'b1;
      end
      if (in_acc) begin
        rd_init_r <= mem_init_r;
        fwd_r     <= wr_en;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
    if (wr_en) begin
      wr_flags_r <= new_flags;
    end
    if (s1_go) begin
      out_char_r <= dec_char;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_char_r};

endmodule
